// ----- rtl/core/lavpm_pkg.sv -----
`default_nettype none

package lavpm_pkg;

  // Default coordinate width, clamped to 16..32 inside the block
  localparam int COORD_WIDTH_DEF = 32;

  // Projection constants, Q16.16
  localparam int ONE_Q16 = 65536;
  localparam int PROJ_F  = 158218;
  localparam int PROJ_ZZ = -65667;
  localparam int PROJ_ZW = -13120;

  // Configuration register indexes
  localparam logic CFG_SURFACE_WIDTH  = 1'b0;
  localparam logic CFG_SURFACE_HEIGHT = 1'b1;
  localparam int   CFG_W              = 15;

  // Rows per request and minimum spacing of requests
  localparam int         ITEM_GAP = 8;
  localparam logic [2:0] ROW_LAST = 3'd7;

  // Vector into a normalize unit (magnitude up to 2^31)
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } in_vec_t;

  // Unit vector out of a normalize unit, signed 18-bit Q2.16
  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } unit_vec_t;

  // Aspect divider sequencer
  typedef enum logic [2:0] {
    ASP_IDLE = 3'b001,
    ASP_MUL  = 3'b010,
    ASP_DIV  = 3'b100
  } asp_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/look_at_view_and_perspective_matrix.sv -----
`default_nettype none

// Camera matrix block. A request (start while busy is low) carries the eye
// position and look direction in signed Q16.16; once it has passed both
// normalize pipelines and the matrix stages, the block strobes out eight
// consecutive rows, one per cycle: view rows 0-3, then projection rows 4-7,
// with last_row on row 7. The receiver cannot stall, so results must be
// taken on the strobe. After an accept busy stays high for as long as the
// row sequencer spends on one result set; the two normalize pipelines and
// the matrix stages behind them hold several requests at once. After reset
// and after every configuration write busy stays high while the serial
// aspect divider works out the projection x scale.
module look_at_view_and_perspective_matrix #(
  parameter int COORD_WIDTH = lavpm_pkg::COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [31:0]                 in_eye_x,
  input  logic [31:0]                 in_eye_y,
  input  logic [31:0]                 in_eye_z,
  input  logic [31:0]                 in_look_x,
  input  logic [31:0]                 in_look_y,
  input  logic [31:0]                 in_look_z,
  output logic                        out_strobe,
  output logic [2:0]                  out_row_index,
  output logic [31:0]                 out_col0,
  output logic [31:0]                 out_col1,
  output logic [31:0]                 out_col2,
  output logic [31:0]                 out_col3,
  output logic                        out_last_row,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [lavpm_pkg::CFG_W-1:0] cfg_data
);

  localparam int CW        = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
  localparam int GAP_W     = $clog2(lavpm_pkg::ITEM_GAP);
  localparam int ASP_STEPS = 33;
  localparam logic signed [39:0] SAT_HI = (40'sd1 <<< (CW - 1)) - 40'sd1;
  localparam logic signed [39:0] SAT_LO = -SAT_HI - 40'sd1;

  // Sign-extend from the low CW bits
  function automatic logic signed [31:0] sext_cw(input logic [31:0] raw);
    logic signed [31:0] t;
    t = signed'(raw << (32 - CW));
    return t >>> (32 - CW);
  endfunction

  // Shift right by 16, round half away from zero
  function automatic logic signed [37:0] rnd16(input logic signed [53:0] v);
    logic [53:0] mag;
    logic [53:0] sh;
    mag = v[53] ? 54'(-v) : 54'(v);
    sh  = (mag + 54'd32768) >> 16;
    return v[53] ? -signed'(sh[37:0]) : signed'(sh[37:0]);
  endfunction

  // Clamp to the signed CW range, sent as 32-bit two's complement
  function automatic logic [31:0] sat_cw(input logic signed [39:0] v);
    logic signed [39:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return c[31:0];
  endfunction

  // Request admission: one request per row-sequencer period
  logic                  accept;
  logic [GAP_W-1:0]      gap_r;
  lavpm_pkg::asp_state_t asp_r;

  assign accept = start && !busy;
  assign busy   = (gap_r != '0) || (asp_r != lavpm_pkg::ASP_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
    end else if (accept) begin
      gap_r <= GAP_W'(lavpm_pkg::ITEM_GAP - 1);
    end else if (gap_r != '0) begin
      gap_r <= gap_r - 1'b1;
    end
  end

  // Config registers and serial aspect divider:
  // a00 = (F * height + width / 2) / width; width zero gives all ones
  logic [lavpm_pkg::CFG_W-1:0] surf_w_r;
  logic [lavpm_pkg::CFG_W-1:0] surf_h_r;
  logic [32:0]                 anum_r;
  logic [14:0]                 arem_r;
  logic [5:0]                  acnt_r;
  logic [32:0]                 asp_prod;
  logic [15:0]                 asp_t;
  logic                        asp_ge;

  assign asp_prod = 33'(lavpm_pkg::PROJ_F) * 33'(surf_h_r);
  assign asp_t    = {arem_r, anum_r[32]};
  assign asp_ge   = (asp_t >= {1'b0, surf_w_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_w_r <= 15'd1;
      surf_h_r <= 15'd1;
      asp_r    <= lavpm_pkg::ASP_MUL;
    end else if (cfg_we) begin
      case (cfg_index)
        lavpm_pkg::CFG_SURFACE_WIDTH:  surf_w_r <= cfg_data;
        lavpm_pkg::CFG_SURFACE_HEIGHT: surf_h_r <= cfg_data;
        default: ;
      endcase
      asp_r <= lavpm_pkg::ASP_MUL;
    end else begin
      case (asp_r)
        lavpm_pkg::ASP_MUL: begin
          anum_r <= asp_prod + 33'(surf_w_r >> 1);
          arem_r <= 15'd0;
          acnt_r <= 6'd0;
          asp_r  <= lavpm_pkg::ASP_DIV;
        end
        lavpm_pkg::ASP_DIV: begin
          arem_r <= asp_ge ? 15'(asp_t - {1'b0, surf_w_r}) : asp_t[14:0];
          anum_r <= {anum_r[31:0], asp_ge};
          acnt_r <= acnt_r + 6'd1;
          if (acnt_r == 6'(ASP_STEPS - 1)) asp_r <= lavpm_pkg::ASP_IDLE;
        end
        lavpm_pkg::ASP_IDLE: ;
        default: asp_r <= lavpm_pkg::ASP_IDLE;
      endcase
    end
  end

  // z = normalize(-look), eye travels as side data
  lavpm_pkg::in_vec_t   nl_vec;
  logic                 z_valid;
  lavpm_pkg::unit_vec_t z_vec;
  logic [95:0]          eye_side;
  logic [95:0]          eye_z_side;

  assign nl_vec.x = -33'(sext_cw(in_look_x));
  assign nl_vec.y = -33'(sext_cw(in_look_y));
  assign nl_vec.z = -33'(sext_cw(in_look_z));

  lavpm_norm #(
    .SIDE_W (96)
  ) u_norm_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_vec    (nl_vec),
    .in_side   ({sext_cw(in_eye_x), sext_cw(in_eye_y), sext_cw(in_eye_z)}),
    .out_valid (z_valid),
    .out_vec   (z_vec),
    .out_side  (eye_z_side)
  );

  // x = normalize(up cross z) = normalize(z.z, 0, -z.x)
  lavpm_pkg::in_vec_t   c_vec;
  logic                 x_valid;
  lavpm_pkg::unit_vec_t x_vec;
  lavpm_pkg::unit_vec_t zd_vec;
  logic [149:0]         side2;

  assign c_vec.x = 33'(z_vec.z);
  assign c_vec.y = 33'sd0;
  assign c_vec.z = -33'(z_vec.x);

  lavpm_norm #(
    .SIDE_W (150)
  ) u_norm_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (z_valid),
    .in_vec    (c_vec),
    .in_side   ({eye_z_side, z_vec}),
    .out_valid (x_valid),
    .out_vec   (x_vec),
    .out_side  (side2)
  );

  assign eye_side = side2[149:54];
  assign zd_vec   = side2[53:0];

  logic signed [31:0] eye_in [3];
  logic signed [17:0] xv [3];
  logic signed [17:0] zv [3];

  assign eye_in[0] = eye_side[95:64];
  assign eye_in[1] = eye_side[63:32];
  assign eye_in[2] = eye_side[31:0];
  assign xv[0] = x_vec.x;
  assign xv[1] = x_vec.y;
  assign xv[2] = x_vec.z;
  assign zv[0] = zd_vec.x;
  assign zv[1] = zd_vec.y;
  assign zv[2] = zd_vec.z;

  // T1: cross and dot products
  logic               v1_r;
  logic signed [35:0] pya_r [3];
  logic signed [35:0] pyb_r [3];
  logic signed [49:0] px_r  [3];
  logic signed [49:0] pz_r  [3];
  logic signed [17:0] x1_r  [3];
  logic signed [17:0] z1_r  [3];
  logic signed [31:0] eye1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= x_valid;
    end
  end

  always_ff @(posedge clk) begin
    pya_r[0] <= zv[1] * xv[2];
    pyb_r[0] <= zv[2] * xv[1];
    pya_r[1] <= zv[2] * xv[0];
    pyb_r[1] <= zv[0] * xv[2];
    pya_r[2] <= zv[0] * xv[1];
    pyb_r[2] <= zv[1] * xv[0];
    for (int i = 0; i < 3; i++) begin
      px_r[i]   <= xv[i] * eye_in[i];
      pz_r[i]   <= zv[i] * eye_in[i];
      x1_r[i]   <= xv[i];
      z1_r[i]   <= zv[i];
      eye1_r[i] <= eye_in[i];
    end
  end

  // T2: y = z cross x, tx, tz
  logic               v2_r;
  logic signed [19:0] y2_r [3];
  logic signed [37:0] tx2_r;
  logic signed [37:0] tz2_r;
  logic signed [17:0] x2_r [3];
  logic signed [17:0] z2_r [3];
  logic signed [31:0] eye2_r [3];
  logic signed [37:0] yr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      yr[i] = rnd16(54'(pya_r[i]) - 54'(pyb_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      y2_r[i]   <= yr[i][19:0];
      x2_r[i]   <= x1_r[i];
      z2_r[i]   <= z1_r[i];
      eye2_r[i] <= eye1_r[i];
    end
    tx2_r <= -rnd16(54'(px_r[0]) + 54'(px_r[1]) + 54'(px_r[2]));
    tz2_r <= -rnd16(54'(pz_r[0]) + 54'(pz_r[1]) + 54'(pz_r[2]));
  end

  // T3: y dot eye products
  logic               v3_r;
  logic signed [51:0] py3_r [3];
  logic signed [19:0] y3_r [3];
  logic signed [17:0] x3_r [3];
  logic signed [17:0] z3_r [3];
  logic signed [37:0] tx3_r;
  logic signed [37:0] tz3_r;
  logic signed [37:0] ty3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      py3_r[i] <= y2_r[i] * eye2_r[i];
      y3_r[i]  <= y2_r[i];
      x3_r[i]  <= x2_r[i];
      z3_r[i]  <= z2_r[i];
    end
    tx3_r <= tx2_r;
    tz3_r <= tz2_r;
  end

  assign ty3 = -rnd16(54'(py3_r[0]) + 54'(py3_r[1]) + 54'(py3_r[2]));

  // Row bank and sequencer: ty finished and everything saturated on load
  logic [31:0] bank_r [3][4];
  logic        strobe_r;
  logic [2:0]  row_r;

  always_ff @(posedge clk) begin
    if (v3_r) begin
      for (int i = 0; i < 3; i++) begin
        bank_r[0][i] <= sat_cw(40'(x3_r[i]));
        bank_r[1][i] <= sat_cw(40'(y3_r[i]));
        bank_r[2][i] <= sat_cw(40'(z3_r[i]));
      end
      bank_r[0][3] <= sat_cw(40'(tx3_r));
      bank_r[1][3] <= sat_cw(40'(ty3));
      bank_r[2][3] <= sat_cw(40'(tz3_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      row_r    <= 3'd0;
    end else if (v3_r) begin
      strobe_r <= 1'b1;
      row_r    <= 3'd0;
    end else if (strobe_r) begin
      if (row_r == lavpm_pkg::ROW_LAST) begin
        strobe_r <= 1'b0;
      end else begin
        row_r <= row_r + 3'd1;
      end
    end
  end

  // Row select
  logic [31:0] col [4];
  logic [31:0] zero_q;

  assign zero_q = sat_cw(40'sd0);

  always_comb begin
    col[0] = zero_q;
    col[1] = zero_q;
    col[2] = zero_q;
    col[3] = zero_q;
    case (row_r)
      3'd0: for (int c = 0; c < 4; c++) col[c] = bank_r[0][c];
      3'd1: for (int c = 0; c < 4; c++) col[c] = bank_r[1][c];
      3'd2: for (int c = 0; c < 4; c++) col[c] = bank_r[2][c];
      3'd3: col[3] = sat_cw(40'(lavpm_pkg::ONE_Q16));
      3'd4: col[0] = sat_cw(signed'(40'(anum_r)));
      3'd5: col[1] = sat_cw(40'(lavpm_pkg::PROJ_F));
      3'd6: begin
        col[2] = sat_cw(40'(lavpm_pkg::PROJ_ZZ));
        col[3] = sat_cw(40'(lavpm_pkg::PROJ_ZW));
      end
      3'd7: col[2] = sat_cw(-40'(lavpm_pkg::ONE_Q16));
      default: ;
    endcase
  end

  assign out_strobe    = strobe_r;
  assign out_row_index = row_r;
  assign out_col0      = col[0];
  assign out_col1      = col[1];
  assign out_col2      = col[2];
  assign out_col3      = col[3];
  assign out_last_row  = (row_r == lavpm_pkg::ROW_LAST);

endmodule

`default_nettype wire

// ----- rtl/core/lavpm_norm.sv -----
`default_nettype none

// Pipelined 3-vector normalize: scale, sum of squares, bit-serial sqrt
// stages, then three long-division lanes. Side data travels along.
module lavpm_norm #(
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  lavpm_pkg::in_vec_t    in_vec,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output lavpm_pkg::unit_vec_t  out_vec,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 17;

  // Stage A: magnitudes and signs
  logic signed [32:0] vin [3];
  logic signed [32:0] vabs [3];
  logic [2:0][31:0]   mag_in;
  logic [2:0]         neg_in;

  assign vin[0] = in_vec.x;
  assign vin[1] = in_vec.y;
  assign vin[2] = in_vec.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_in[i] = vin[i][32];
      vabs[i]   = neg_in[i] ? -vin[i] : vin[i];
      mag_in[i] = vabs[i][31:0];
    end
  end

  logic              va_r;
  logic [2:0][31:0]  mag_a_r;
  logic [2:0]        neg_a_r;
  logic [SIDE_W-1:0] side_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    mag_a_r  <= mag_in;
    neg_a_r  <= neg_in;
    side_a_r <= in_side;
  end

  // Stage B: largest magnitude and scale shift into [2^30, 2^31]
  logic [31:0] m_b;
  logic [4:0]  k_b;

  always_comb begin
    m_b = mag_a_r[0];
    if (mag_a_r[1] > m_b) m_b = mag_a_r[1];
    if (mag_a_r[2] > m_b) m_b = mag_a_r[2];
    k_b = 5'd0;
    for (int b = 0; b < 31; b++) begin
      if (m_b[b]) k_b = 5'(30 - b);
    end
  end

  logic              vb_r;
  logic [2:0][31:0]  mag_b_r;
  logic [2:0]        neg_b_r;
  logic [4:0]        k_b_r;
  logic              zero_b_r;
  logic [SIDE_W-1:0] side_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_b_r  <= mag_a_r;
    neg_b_r  <= neg_a_r;
    k_b_r    <= k_b;
    zero_b_r <= (m_b == 32'd0);
    side_b_r <= side_a_r;
  end

  // Stage C: scaled magnitudes
  logic              vc_r;
  logic [2:0][31:0]  w_c_r;
  logic [2:0]        neg_c_r;
  logic              zero_c_r;
  logic [SIDE_W-1:0] side_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      w_c_r[i] <= mag_b_r[i] << k_b_r;
    end
    neg_c_r  <= neg_b_r;
    zero_c_r <= zero_b_r;
    side_c_r <= side_b_r;
  end

  // Stage D: squares
  logic              vd_r;
  logic [2:0][63:0]  sq_d_r;
  logic [2:0][31:0]  w_d_r;
  logic [2:0]        neg_d_r;
  logic              zero_d_r;
  logic [SIDE_W-1:0] side_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_d_r[i] <= 64'(w_c_r[i]) * 64'(w_c_r[i]);
    end
    w_d_r    <= w_c_r;
    neg_d_r  <= neg_c_r;
    zero_d_r <= zero_c_r;
    side_d_r <= side_c_r;
  end

  // Stage E: sum of squares (at most 3 * 2^62)
  logic              ve_r;
  logic [63:0]       s_e_r;
  logic [2:0][31:0]  w_e_r;
  logic [2:0]        neg_e_r;
  logic              zero_e_r;
  logic [SIDE_W-1:0] side_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else begin
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    s_e_r    <= sq_d_r[0] + sq_d_r[1] + sq_d_r[2];
    w_e_r    <= w_d_r;
    neg_e_r  <= neg_d_r;
    zero_e_r <= zero_d_r;
    side_e_r <= side_d_r;
  end

  // Square root: one result bit per stage
  logic              sv_r    [SQ_STEPS];
  logic [63:0]       sqs_r   [SQ_STEPS];
  logic [31:0]       root_r  [SQ_STEPS];
  logic [34:0]       srem_r  [SQ_STEPS];
  logic [2:0][31:0]  sw_r    [SQ_STEPS];
  logic [2:0]        sneg_r  [SQ_STEPS];
  logic              szero_r [SQ_STEPS];
  logic [SIDE_W-1:0] sside_r [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    logic              p_v;
    logic [63:0]       p_s;
    logic [31:0]       p_root;
    logic [34:0]       p_rem;
    logic [2:0][31:0]  p_w;
    logic [2:0]        p_neg;
    logic              p_zero;
    logic [SIDE_W-1:0] p_side;
    logic [34:0]       rem_t;
    logic [34:0]       trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign p_v    = ve_r;
      assign p_s    = s_e_r;
      assign p_root = 32'd0;
      assign p_rem  = 35'd0;
      assign p_w    = w_e_r;
      assign p_neg  = neg_e_r;
      assign p_zero = zero_e_r;
      assign p_side = side_e_r;
    end else begin : g_next
      assign p_v    = sv_r[j-1];
      assign p_s    = sqs_r[j-1];
      assign p_root = root_r[j-1];
      assign p_rem  = srem_r[j-1];
      assign p_w    = sw_r[j-1];
      assign p_neg  = sneg_r[j-1];
      assign p_zero = szero_r[j-1];
      assign p_side = sside_r[j-1];
    end

    assign rem_t = {p_rem[32:0], p_s[63:62]};
    assign trial = {1'b0, p_root, 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j] <= 1'b0;
      end else begin
        sv_r[j] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      sqs_r[j]   <= {p_s[61:0], 2'b00};
      srem_r[j]  <= ge ? (rem_t - trial) : rem_t;
      root_r[j]  <= {p_root[30:0], ge};
      sw_r[j]    <= p_w;
      sneg_r[j]  <= p_neg;
      szero_r[j] <= p_zero;
      sside_r[j] <= p_side;
    end
  end

  // Stage F: dividends w*2^16 + n/2, divisor n
  logic [31:0]      n_f;
  logic [2:0][47:0] num_f;

  assign n_f = root_r[SQ_STEPS-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_f[i] = {sw_r[SQ_STEPS-1][i], 16'd0} + {17'd0, n_f[31:1]};
    end
  end

  logic              fv_r;
  logic [2:0][31:0]  frem_r;
  logic [2:0][16:0]  fnq_r;
  logic [31:0]       fd_r;
  logic [2:0]        fneg_r;
  logic              fzero_r;
  logic [SIDE_W-1:0] fside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= sv_r[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      frem_r[i] <= {1'b0, num_f[i][47:17]};
      fnq_r[i]  <= num_f[i][16:0];
    end
    fd_r    <= n_f;
    fneg_r  <= sneg_r[SQ_STEPS-1];
    fzero_r <= szero_r[SQ_STEPS-1];
    fside_r <= sside_r[SQ_STEPS-1];
  end

  // Long division: one quotient bit per stage in each lane
  logic              dv_r    [DIV_STEPS];
  logic [2:0][31:0]  drem_r  [DIV_STEPS];
  logic [2:0][16:0]  dnq_r   [DIV_STEPS];
  logic [31:0]       dd_r    [DIV_STEPS];
  logic [2:0]        dneg_r  [DIV_STEPS];
  logic              dzero_r [DIV_STEPS];
  logic [SIDE_W-1:0] dside_r [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic              p_v;
    logic [2:0][31:0]  p_rem;
    logic [2:0][16:0]  p_nq;
    logic [31:0]       p_d;
    logic [2:0]        p_neg;
    logic              p_zero;
    logic [SIDE_W-1:0] p_side;
    logic [2:0][32:0]  t;
    logic [2:0][32:0]  diff;
    logic [2:0]        ge;

    if (j == 0) begin : g_first
      assign p_v    = fv_r;
      assign p_rem  = frem_r;
      assign p_nq   = fnq_r;
      assign p_d    = fd_r;
      assign p_neg  = fneg_r;
      assign p_zero = fzero_r;
      assign p_side = fside_r;
    end else begin : g_next
      assign p_v    = dv_r[j-1];
      assign p_rem  = drem_r[j-1];
      assign p_nq   = dnq_r[j-1];
      assign p_d    = dd_r[j-1];
      assign p_neg  = dneg_r[j-1];
      assign p_zero = dzero_r[j-1];
      assign p_side = dside_r[j-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]    = {p_rem[i], p_nq[i][16]};
        diff[i] = t[i] - {1'b0, p_d};
        ge[i]   = (t[i] >= {1'b0, p_d});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else begin
        dv_r[j] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        drem_r[j][i] <= ge[i] ? diff[i][31:0] : t[i][31:0];
        dnq_r[j][i]  <= {p_nq[i][15:0], ge[i]};
      end
      dd_r[j]    <= p_d;
      dneg_r[j]  <= p_neg;
      dzero_r[j] <= p_zero;
      dside_r[j] <= p_side;
    end
  end

  // Output stage: signs back on, zero vector stays zero
  logic signed [17:0] qs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = signed'({1'b0, dnq_r[DIV_STEPS-1][i]});
      if (dzero_r[DIV_STEPS-1]) begin
        qs[i] = 18'sd0;
      end else if (dneg_r[DIV_STEPS-1][i]) begin
        qs[i] = -qs[i];
      end
    end
  end

  logic                 ov_r;
  lavpm_pkg::unit_vec_t ovec_r;
  logic [SIDE_W-1:0]    oside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= dv_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    ovec_r.x <= qs[0];
    ovec_r.y <= qs[1];
    ovec_r.z <= qs[2];
    oside_r  <= dside_r[DIV_STEPS-1];
  end

  assign out_valid = ov_r;
  assign out_vec   = ovec_r;
  assign out_side  = oside_r;

endmodule

`default_nettype wire

// ----- rtl/core/lavpm_check.sv -----
`default_nettype none

// Port-level checks on admission and row sequencing
module lavpm_check (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [2:0] out_row_index,
  input logic       out_last_row
);

  // An accepted request closes the door for the following cycle
  a_throttle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken without busy following");

  // Rows of a set come back to back in order
  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_row_index != lavpm_pkg::ROW_LAST) |=>
      out_strobe && (out_row_index == $past(out_row_index) + 3'd1))
    else $error("row sequence broken");

  // A result set opens with row 0
  a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> (out_row_index == 3'd0))
    else $error("result set does not start at row 0");

  // Last-row flag marks row 7 only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_last_row == (out_row_index == lavpm_pkg::ROW_LAST)))
    else $error("last_row flag wrong");

endmodule

bind look_at_view_and_perspective_matrix lavpm_check u_lavpm_check (.*);

`default_nettype wire
